/* design/tvr_pkg.sv */
package tvr_pkg;

   localparam int MU_BITS = 8;
   localparam int SCALE_W = 16;
   localparam int IDX_W   = 10;
   localparam int P1_W    = SCALE_W + IDX_W - MU_BITS;

   localparam logic [1:0] CSR_SCALE_X = 2'd0;
   localparam logic [1:0] CSR_SCALE_Y = 2'd1;
   localparam logic [1:0] CSR_SCALE_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_ZGO,
      ST_ZWAIT,
      ST_YGO,
      ST_YWAIT,
      ST_XGO,
      ST_XWAIT
   } state_type;

   typedef enum logic [1:0] {
      STG_Z,
      STG_Y,
      STG_X
   } stage_type;

   typedef struct packed {
      logic       wr;
      logic       load;
      logic       rd;
      logic       cub_go;
      stage_type  stage;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
   } cmd_type;

endpackage

/* design/tvr_cubic.sv */
module tvr_cubic #(
   parameter int VW = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [VW-1:0] y0,
   input  logic signed [VW-1:0] y1,
   input  logic signed [VW-1:0] y2,
   input  logic signed [VW-1:0] y3,
   input  logic [tvr_pkg::MU_BITS-1:0] mu,
   output logic                 done,
   output logic signed [VW-1:0] res
);

   localparam int MU = tvr_pkg::MU_BITS;
   localparam int AW = VW + 3 * MU + 6;

   logic signed [VW+1:0]  a0, a1, a2;
   logic signed [VW+1:0]  a1_ff, a2_ff;
   logic signed [VW-1:0]  y1_ff, res_ff;
   logic [MU-1:0]         mu_ff;
   logic signed [AW-1:0]  t_ff, t_in, addend;
   logic signed [AW+MU:0] prod;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  done_ff;

   assign a0 = (VW+2)'(y3) - (VW+2)'(y2) - (VW+2)'(y0) + (VW+2)'(y1);
   assign a1 = (VW+2)'(y0) - (VW+2)'(y1) - a0;
   assign a2 = (VW+2)'(y2) - (VW+2)'(y0);

   // Horner form: ((a0*m + a1<<8)*m + a2<<16)*m, one multiply per step
   assign prod = t_ff * $signed({1'b0, mu_ff});

   always_comb begin
      unique case (cnt_ff)
         3'd1:    addend = AW'(a1_ff) <<< MU;
         3'd2:    addend = AW'(a2_ff) <<< (2 * MU);
         default: addend = '0;
      endcase
      t_in   = AW'(prod) + addend;
      cnt_in = (cnt_ff == 3'd0) ? 3'd0 : ((cnt_ff == 3'd4) ? 3'd0 : cnt_ff + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= start ? 3'd1 : cnt_in;
         done_ff <= (cnt_ff == 3'd4);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         t_ff  <= AW'(a0);
         a1_ff <= a1;
         a2_ff <= a2;
         y1_ff <= y1;
         mu_ff <= mu;
      end else if (cnt_ff == 3'd4) begin
         res_ff <= VW'(t_ff >>> (3 * MU)) + y1_ff;
      end else if (cnt_ff != 3'd0) begin
         t_ff <= t_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

/* design/tvr_ctrl.sv */
module tvr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_func,
   input  logic             cub_done,
   output logic             busy,
   output tvr_pkg::cmd_type cmd
);

   tvr_pkg::state_type state_ff, state_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         tvr_pkg::ST_IDLE: begin
            if (start && req_func) begin
               state_in = tvr_pkg::ST_READ;
               i_in     = 2'd0;
               j_in     = 2'd0;
               k_in     = 2'd0;
            end
         end
         tvr_pkg::ST_READ: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = tvr_pkg::ST_LAST;
            end
         end
         tvr_pkg::ST_LAST: state_in = tvr_pkg::ST_ZGO;
         tvr_pkg::ST_ZGO:  state_in = tvr_pkg::ST_ZWAIT;
         tvr_pkg::ST_ZWAIT: begin
            if (cub_done) begin
               if (j_ff == 2'd3) begin
                  state_in = tvr_pkg::ST_YGO;
               end else begin
                  j_in     = j_ff + 2'd1;
                  state_in = tvr_pkg::ST_READ;
               end
            end
         end
         tvr_pkg::ST_YGO: state_in = tvr_pkg::ST_YWAIT;
         tvr_pkg::ST_YWAIT: begin
            if (cub_done) begin
               if (i_ff == 2'd3) begin
                  state_in = tvr_pkg::ST_XGO;
               end else begin
                  i_in     = i_ff + 2'd1;
                  j_in     = 2'd0;
                  state_in = tvr_pkg::ST_READ;
               end
            end
         end
         tvr_pkg::ST_XGO: state_in = tvr_pkg::ST_XWAIT;
         tvr_pkg::ST_XWAIT: begin
            if (cub_done) begin
               state_in = tvr_pkg::ST_IDLE;
            end
         end
         default: state_in = tvr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = (state_ff != tvr_pkg::ST_IDLE);
      cmd.wr     = (state_ff == tvr_pkg::ST_IDLE) && start && !req_func;
      cmd.load   = (state_ff == tvr_pkg::ST_IDLE) && start && req_func;
      cmd.rd     = (state_ff == tvr_pkg::ST_READ);
      cmd.cub_go = 1'b0;
      cmd.stage  = tvr_pkg::STG_Z;
      cmd.i      = i_ff;
      cmd.j      = j_ff;
      cmd.k      = k_ff;
      unique case (state_ff)
         tvr_pkg::ST_ZGO:   cmd.cub_go = 1'b1;
         tvr_pkg::ST_YGO: begin
            cmd.cub_go = 1'b1;
            cmd.stage  = tvr_pkg::STG_Y;
         end
         tvr_pkg::ST_YWAIT: cmd.stage = tvr_pkg::STG_Y;
         tvr_pkg::ST_XGO: begin
            cmd.cub_go = 1'b1;
            cmd.stage  = tvr_pkg::STG_X;
         end
         tvr_pkg::ST_XWAIT: cmd.stage = tvr_pkg::STG_X;
         default: cmd.cub_go = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvr_pkg::ST_IDLE;
         i_ff     <= 2'd0;
         j_ff     <= 2'd0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

/* design/tvr_dp.sv */
module tvr_dp #(
   parameter int DIM_X     = 32,
   parameter int DIM_Y     = 32,
   parameter int DIM_Z     = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  tvr_pkg::cmd_type cmd,
   output logic             cub_done,
   input  logic [4:0]       req_wr_x,
   input  logic [4:0]       req_wr_y,
   input  logic [4:0]       req_wr_z,
   input  logic [7:0]       req_voxel,
   input  logic [tvr_pkg::IDX_W-1:0] req_out_x,
   input  logic [tvr_pkg::IDX_W-1:0] req_out_y,
   input  logic [tvr_pkg::IDX_W-1:0] req_out_z,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [tvr_pkg::SCALE_W-1:0] csr_wdata,
   output logic             rsp_valid,
   output logic [7:0]       rsp_value,
   output logic             rsp_saturated
);

   localparam int MU    = tvr_pkg::MU_BITS;
   localparam int PW    = tvr_pkg::P1_W;
   localparam int POS_W = tvr_pkg::SCALE_W + tvr_pkg::IDX_W;
   localparam int XW    = $clog2(DIM_X);
   localparam int YW    = $clog2(DIM_Y);
   localparam int ZW    = $clog2(DIM_Z);
   localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
   localparam int MW    = $clog2(DEPTH);
   localparam int VW    = 8 + FRAC_BITS + 3;

   function automatic logic [3:0][7:0] nbr_fn(input logic [PW-1:0] p1, input logic [7:0] lim);
      logic [PW:0] c;
      logic [PW:0] l;
      l = (PW+1)'(lim);
      for (int n = 0; n < 4; n++) begin
         c = (PW+1)'(p1) + (PW+1)'(n) - (PW+1)'(1);
         if (n == 0 && p1 == '0) begin
            c = '0;
         end
         nbr_fn[n] = (c > l) ? lim : c[7:0];
      end
   endfunction

   function automatic logic [MW-1:0] addr_fn(input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] z);
      return MW'((32'(z) * 32'(DIM_Y) + 32'(y)) * 32'(DIM_X) + 32'(x));
   endfunction

   logic [tvr_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff, scale_z_ff;
   logic [POS_W-1:0] pos_x, pos_y, pos_z;
   logic [3:0][7:0]  nbx, nby, nbz;
   logic [XW-1:0]    nx_ff [4];
   logic [YW-1:0]    ny_ff [4];
   logic [ZW-1:0]    nz_ff [4];
   logic [MU-1:0]    mx_ff, my_ff, mz_ff;

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rdata_ff;
   logic             rd_valid_ff;
   logic [MW-1:0]    mem_addr;
   logic             wr_ok;

   logic signed [VW-1:0] win_ff [4];
   logic signed [VW-1:0] p_ff [4];
   logic signed [VW-1:0] w_ff [4];
   logic signed [VW-1:0] op0, op1, op2, op3, cub_res, fl;
   logic [MU-1:0]        op_mu;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_value_ff;
   logic                 rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= tvr_pkg::SCALE_W'(256);
         scale_y_ff <= tvr_pkg::SCALE_W'(256);
         scale_z_ff <= tvr_pkg::SCALE_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            tvr_pkg::CSR_SCALE_X: scale_x_ff <= csr_wdata;
            tvr_pkg::CSR_SCALE_Y: scale_y_ff <= csr_wdata;
            tvr_pkg::CSR_SCALE_Z: scale_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pos_x = req_out_x * scale_x_ff;
   assign pos_y = req_out_y * scale_y_ff;
   assign pos_z = req_out_z * scale_z_ff;
   assign nbx   = nbr_fn(pos_x[POS_W-1:MU], 8'(DIM_X - 1));
   assign nby   = nbr_fn(pos_y[POS_W-1:MU], 8'(DIM_Y - 1));
   assign nbz   = nbr_fn(pos_z[POS_W-1:MU], 8'(DIM_Z - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int n = 0; n < 4; n++) begin
            nx_ff[n] <= nbx[n][XW-1:0];
            ny_ff[n] <= nby[n][YW-1:0];
            nz_ff[n] <= nbz[n][ZW-1:0];
         end
         mx_ff <= pos_x[MU-1:0];
         my_ff <= pos_y[MU-1:0];
         mz_ff <= pos_z[MU-1:0];
      end
   end

   // writes outside a smaller volume are dropped
   assign wr_ok = (9'(req_wr_x) < 9'(DIM_X)) && (9'(req_wr_y) < 9'(DIM_Y)) &&
                  (9'(req_wr_z) < 9'(DIM_Z));

   assign mem_addr = cmd.wr ? addr_fn(8'(req_wr_x), 8'(req_wr_y), 8'(req_wr_z))
                            : addr_fn(8'(nx_ff[cmd.i]), 8'(ny_ff[cmd.j]), 8'(nz_ff[cmd.k]));

   always_ff @(posedge clock) begin
      if (cmd.wr && wr_ok) begin
         mem[mem_addr] <= req_voxel;
      end
      rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= win_ff[3];
         win_ff[3] <= VW'({rdata_ff, FRAC_BITS'(0)});
      end
   end

   always_comb begin
      unique case (cmd.stage)
         tvr_pkg::STG_Y: begin
            op0 = p_ff[0]; op1 = p_ff[1]; op2 = p_ff[2]; op3 = p_ff[3]; op_mu = my_ff;
         end
         tvr_pkg::STG_X: begin
            op0 = w_ff[0]; op1 = w_ff[1]; op2 = w_ff[2]; op3 = w_ff[3]; op_mu = mx_ff;
         end
         default: begin
            op0 = win_ff[0]; op1 = win_ff[1]; op2 = win_ff[2]; op3 = win_ff[3];
            op_mu = mz_ff;
         end
      endcase
   end

   tvr_cubic #(.VW(VW)) u_cubic (
      .clock (clock),
      .reset (reset),
      .start (cmd.cub_go),
      .y0    (op0),
      .y1    (op1),
      .y2    (op2),
      .y3    (op3),
      .mu    (op_mu),
      .done  (cub_done),
      .res   (cub_res)
   );

   assign fl = cub_res >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (cub_done) begin
         unique case (cmd.stage)
            tvr_pkg::STG_Y: w_ff[cmd.i] <= cub_res;
            tvr_pkg::STG_X: begin
               if (fl < 0) begin
                  rsp_value_ff <= 8'd0;
                  rsp_sat_ff   <= 1'b1;
               end else if (fl > VW'(255)) begin
                  rsp_value_ff <= 8'd255;
                  rsp_sat_ff   <= 1'b1;
               end else begin
                  rsp_value_ff <= fl[7:0];
                  rsp_sat_ff   <= 1'b0;
               end
            end
            default: p_ff[cmd.j] <= cub_res;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cub_done && (cmd.stage == tvr_pkg::STG_X);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

/* design/tricubic_volume_resampler.sv */
// Tricubic resampler over a byte volume held in one single-port memory. A write
// item (req_func low) is taken while idle and busy stays low. A query item
// holds busy high until its result strobes on rsp_valid in the first cycle with
// busy low: 16 columns of 4 serial memory reads, each followed by a z pass of the
// shared cubic unit, with a y pass after every fourth column and 1 x pass at the
// end. rsp_valid is
// high for a single cycle and cannot be held off, so the receiver must take it.
module tricubic_volume_resampler #(
   parameter int DIM_X     = 32,
   parameter int DIM_Y     = 32,
   parameter int DIM_Z     = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [4:0]  req_wr_x,
   input  logic [4:0]  req_wr_y,
   input  logic [4:0]  req_wr_z,
   input  logic [7:0]  req_voxel,
   input  logic [9:0]  req_out_x,
   input  logic [9:0]  req_out_y,
   input  logic [9:0]  req_out_z,
   output logic        rsp_valid,
   output logic [7:0]  rsp_value,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   tvr_pkg::cmd_type cmd;
   logic             cub_done;

   tvr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .cub_done (cub_done),
      .busy     (busy),
      .cmd      (cmd)
   );

   tvr_dp #(
      .DIM_X     (DIM_X),
      .DIM_Y     (DIM_Y),
      .DIM_Z     (DIM_Z),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cub_done      (cub_done),
      .req_wr_x      (req_wr_x),
      .req_wr_y      (req_wr_y),
      .req_wr_z      (req_wr_z),
      .req_voxel     (req_voxel),
      .req_out_x     (req_out_x),
      .req_out_y     (req_out_y),
      .req_out_z     (req_out_z),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_saturated (rsp_saturated)
   );

endmodule

/* design/tvr_checker.sv */
module tvr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_func,
   input logic       rsp_valid,
   input logic [7:0] rsp_value,
   input logic       rsp_saturated
);

   // one strobe per query, never two in a row
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // a result only ends a query
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy))
      else $error("result without a query in flight");

   // a write item completes at once
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_func |=> !busy)
      else $error("write item made the block busy");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func |=> busy)
      else $error("query item not taken up");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_value == 8'd0 || rsp_value == 8'd255)
      else $error("saturated result not at a rail");

endmodule

bind tricubic_volume_resampler tvr_checker u_tvr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_value     (rsp_value),
   .rsp_saturated (rsp_saturated)
);

/* test/tb_tricubic_volume_resampler.sv */
`timescale 1ns / 1ps

module tb_tricubic_volume_resampler;

   localparam int NX = 32;
   localparam int NY = 32;
   localparam int NZ = 32;
   localparam int VOXELS = NX * NY * NZ;
   localparam int N_RANDOM = 1100;
   // queries stay inside two corner blocks that are fully written first
   localparam int LOW_N     = 8;
   localparam int HIGH_BASE = 28;
   localparam int HIGH_N    = 4;

   localparam bit FN_WRITE = 1'b0;
   localparam bit FN_QUERY = 1'b1;

   typedef struct {
      bit       func;
      bit [4:0] wx, wy, wz;
      bit [7:0] vox;
      bit [9:0] ox, oy, oz;
      bit       typed;
      bit [7:0] exp_value;
      bit       exp_sat;
   } item_type;

   typedef struct {
      bit [7:0] value;
      bit       sat;
   } voxel_out_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [4:0]  req_wr_x, req_wr_y, req_wr_z;
   logic [7:0]  req_voxel;
   logic [9:0]  req_out_x, req_out_y, req_out_z;
   logic        rsp_valid;
   logic [7:0]  rsp_value;
   logic        rsp_saturated;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   bit [7:0]      vol_mirror [VOXELS];
   bit [15:0]     scale_mirror [3];
   voxel_out_type pending_voxels [$];
   int            mismatches;
   int            results_seen;
   int            saturations;
   int            queries_sent;
   int            writes_sent;
   int            burst_left;

   tricubic_volume_resampler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_wr_x(req_wr_x), .req_wr_y(req_wr_y),
      .req_wr_z(req_wr_z), .req_voxel(req_voxel), .req_out_x(req_out_x),
      .req_out_y(req_out_y), .req_out_z(req_out_z), .rsp_valid(rsp_valid),
      .rsp_value(rsp_value), .rsp_saturated(rsp_saturated), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("tb_tricubic_volume_resampler NOT OK");
      $finish;
   end

   // four-point cubic, mu in Q0.8, samples carry 8 fraction bits
   function automatic longint cubic_step(longint y0, longint y1, longint y2, longint y3,
                                         longint m);
      longint a0, a1, a2, acc;
      a0  = y3 - y2 - y0 + y1;
      a1  = y0 - y1 - a0;
      a2  = y2 - y0;
      acc = a0 * m * m * m + a1 * m * m * 256 + a2 * m * 65536;
      return (acc >>> 24) + y1;
   endfunction

   function automatic int unsigned clamp_axis(longint v, int dim);
      return (v >= dim) ? dim - 1 : int'(v);
   endfunction

   function automatic longint axis_taps(bit [9:0] idx, bit [15:0] sc, int dim,
                                        output int unsigned taps [4]);
      longint pos, p1;
      pos = longint'(idx) * longint'(sc);
      p1  = pos >> 8;
      taps[0] = clamp_axis((p1 == 0) ? 0 : p1 - 1, dim);
      taps[1] = clamp_axis(p1, dim);
      taps[2] = clamp_axis(p1 + 1, dim);
      taps[3] = clamp_axis(p1 + 2, dim);
      return pos & 255;
   endfunction

   function automatic longint sample(int unsigned x, int unsigned y, int unsigned z);
      return longint'(vol_mirror[(z * NY + y) * NX + x]) * 256;
   endfunction

   function automatic voxel_out_type resample(bit [9:0] ox, bit [9:0] oy, bit [9:0] oz);
      int unsigned tx [4], ty [4], tz [4];
      longint mx, my, mz, col [4][4], row [4], r, fl;
      voxel_out_type o;
      mx = axis_taps(ox, scale_mirror[tvr_pkg::CSR_SCALE_X], NX, tx);
      my = axis_taps(oy, scale_mirror[tvr_pkg::CSR_SCALE_Y], NY, ty);
      mz = axis_taps(oz, scale_mirror[tvr_pkg::CSR_SCALE_Z], NZ, tz);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            col[i][j] = cubic_step(sample(tx[i], ty[j], tz[0]), sample(tx[i], ty[j], tz[1]),
                                   sample(tx[i], ty[j], tz[2]), sample(tx[i], ty[j], tz[3]),
                                   mz);
      for (int i = 0; i < 4; i++)
         row[i] = cubic_step(col[i][0], col[i][1], col[i][2], col[i][3], my);
      r  = cubic_step(row[0], row[1], row[2], row[3], mx);
      fl = r >>> 8;
      if (fl < 0) begin
         o.value = 8'd0;
         o.sat   = 1'b1;
      end else if (fl > 255) begin
         o.value = 8'd255;
         o.sat   = 1'b1;
      end else begin
         o.value = fl[7:0];
         o.sat   = 1'b0;
      end
      return o;
   endfunction

   task automatic send_item(item_type it);
      voxel_out_type o;
      start     <= 1'b1;
      req_func  <= it.func;
      req_wr_x  <= it.wx;
      req_wr_y  <= it.wy;
      req_wr_z  <= it.wz;
      req_voxel <= it.vox;
      req_out_x <= it.ox;
      req_out_y <= it.oy;
      req_out_z <= it.oz;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (it.func == FN_WRITE) begin
         vol_mirror[(int'(it.wz) * NY + int'(it.wy)) * NX + int'(it.wx)] = it.vox;
         writes_sent++;
      end else begin
         if (it.typed) begin
            o.value = it.exp_value;
            o.sat   = it.exp_sat;
         end else begin
            o = resample(it.ox, it.oy, it.oz);
         end
         pending_voxels.push_back(o);
         queries_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_voxels.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_scales(bit [15:0] sx, bit [15:0] sy, bit [15:0] sz);
      drain();
      csr_we    <= 1'b1;
      csr_index <= tvr_pkg::CSR_SCALE_X;
      csr_wdata <= sx;
      @(posedge clock);
      csr_index <= tvr_pkg::CSR_SCALE_Y;
      csr_wdata <= sy;
      @(posedge clock);
      csr_index <= tvr_pkg::CSR_SCALE_Z;
      csr_wdata <= sz;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      scale_mirror[tvr_pkg::CSR_SCALE_X] = sx;
      scale_mirror[tvr_pkg::CSR_SCALE_Y] = sy;
      scale_mirror[tvr_pkg::CSR_SCALE_Z] = sz;
   endtask

   function automatic item_type write_row(int x, int y, int z, int v);
      item_type it;
      it = '{default: 0};
      it.func = FN_WRITE;
      it.wx = 5'(x);
      it.wy = 5'(y);
      it.wz = 5'(z);
      it.vox = 8'(v);
      return it;
   endfunction

   function automatic item_type query_row(int x, int y, int z, bit typed, int v);
      item_type it;
      it = '{default: 0};
      it.func = FN_QUERY;
      it.ox = 10'(x);
      it.oy = 10'(y);
      it.oz = 10'(z);
      it.typed = typed;
      it.exp_value = 8'(v);
      return it;
   endfunction

   // index whose four taps all fall in the low block, or all in the top block
   function automatic bit [9:0] pick_index(bit [15:0] sc, bit top_block);
      int unsigned lim;
      if (top_block) begin
         lim = ((HIGH_BASE + 1) * 256 + int'(sc) - 1) / int'(sc);
         return 10'($urandom_range(lim, 1023));
      end
      if (sc == 0) return 10'($urandom_range(0, 1023));
      lim = ((LOW_N - 2) * 256 - 1) / int'(sc);
      if (lim > 1023) lim = 1023;
      return ($urandom_range(0, 3) == 0) ? 10'(lim) : 10'($urandom_range(0, lim));
   endfunction

   function automatic item_type rand_item();
      item_type it;
      bit       top_block;
      top_block = (scale_mirror[tvr_pkg::CSR_SCALE_X] >= 16'd8) &&
                  (scale_mirror[tvr_pkg::CSR_SCALE_Y] >= 16'd8) &&
                  (scale_mirror[tvr_pkg::CSR_SCALE_Z] >= 16'd8) &&
                  ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0)
         it = write_row($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 255));
      else
         it = query_row(pick_index(scale_mirror[tvr_pkg::CSR_SCALE_X], top_block),
                        pick_index(scale_mirror[tvr_pkg::CSR_SCALE_Y], top_block),
                        pick_index(scale_mirror[tvr_pkg::CSR_SCALE_Z], top_block), 1'b0, 0);
      // junk on the fields the operation does not use
      if (it.func == FN_WRITE) begin
         it.ox = 10'($urandom_range(0, 1023));
         it.oy = 10'($urandom_range(0, 1023));
         it.oz = 10'($urandom_range(0, 1023));
      end else begin
         it.wx = 5'($urandom_range(0, 31));
         it.wy = 5'($urandom_range(0, 31));
         it.wz = 5'($urandom_range(0, 31));
         it.vox = 8'($urandom_range(0, 255));
      end
      return it;
   endfunction

   always @(posedge clock) begin
      voxel_out_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_saturated) saturations++;
         if (pending_voxels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%0d sat=%0b", rsp_value, rsp_saturated);
         end else begin
            e = pending_voxels.pop_front();
            if (rsp_value !== e.value || rsp_saturated !== e.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                           results_seen, e.value, e.sat, rsp_value, rsp_saturated);
            end
         end
      end
   end

   initial begin
      item_type directed [$];
      reset     = 1'b1;
      start     = 1'b0;
      req_func  = 1'b0;
      req_wr_x  = '0;
      req_wr_y  = '0;
      req_wr_z  = '0;
      req_voxel = '0;
      req_out_x = '0;
      req_out_y = '0;
      req_out_z = '0;
      csr_we    = 1'b0;
      csr_index = tvr_pkg::CSR_SCALE_X;
      csr_wdata = '0;
      mismatches = 0;
      results_seen = 0;
      saturations = 0;
      queries_sent = 0;
      writes_sent = 0;
      burst_left = 0;
      scale_mirror[tvr_pkg::CSR_SCALE_X] = 16'd256;
      scale_mirror[tvr_pkg::CSR_SCALE_Y] = 16'd256;
      scale_mirror[tvr_pkg::CSR_SCALE_Z] = 16'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // both corner blocks get written before any read can reach them
      for (int a = 0; a < LOW_N * LOW_N * LOW_N; a++)
         send_item(write_row(a % LOW_N, (a / LOW_N) % LOW_N, a / (LOW_N * LOW_N),
                             $urandom_range(0, 255)));
      for (int a = 0; a < HIGH_N * HIGH_N * HIGH_N; a++)
         send_item(write_row(HIGH_BASE + a % HIGH_N, HIGH_BASE + (a / HIGH_N) % HIGH_N,
                             HIGH_BASE + a / (HIGH_N * HIGH_N), $urandom_range(0, 255)));

      // unit scale, integer positions: query returns the stored voxel
      directed.push_back(write_row(0, 0, 0, 0));
      directed.push_back(query_row(0, 0, 0, 1'b1, 0));
      directed.push_back(write_row(31, 31, 31, 255));
      directed.push_back(query_row(1023, 1023, 1023, 1'b1, 255));
      directed.push_back(query_row(31, 31, 31, 1'b1, 255));
      directed.push_back(write_row(3, 4, 5, 200));
      directed.push_back(query_row(3, 4, 5, 1'b1, 200));
      directed.push_back(write_row(30, 29, 31, 1));
      directed.push_back(query_row(30, 29, 31, 1'b1, 1));
      directed.push_back(query_row(40, 1000, 1023, 1'b0, 0));
      directed.push_back(query_row(512, 341, 682, 1'b0, 0));
      foreach (directed[n]) send_item(directed[n]);

      // fractional positions, then extreme and zero scales
      set_scales(16'd128, 16'd384, 16'd200);
      for (int n = 0; n < 4; n++)
         send_item(query_row($urandom_range(0, 11), $urandom_range(0, 3),
                             $urandom_range(0, 7), 1'b0, 0));
      send_item(query_row(1023, 1023, 1023, 1'b0, 0));
      set_scales(16'd1, 16'd65535, 16'd0);
      send_item(query_row(1023, 0, 1023, 1'b0, 0));
      send_item(query_row(500, 0, 5, 1'b0, 0));
      send_item(query_row(700, 0, 300, 1'b0, 0));

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_scales(16'd256, 16'd256, 16'd256);
            1: set_scales(16'd65535, 16'd65535, 16'd65535);
            2: set_scales(16'd1, 16'd1, 16'd1);
            3: set_scales(16'd0, 16'd0, 16'd0);
            default: set_scales(16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)),
                                16'($urandom_range(1, 600)));
         endcase
         for (int n = 0; n < ((phase < 4) ? N_RANDOM / 20 : N_RANDOM / 4); n++)
            send_item(rand_item());
      end
      set_scales(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      for (int n = 0; n < 60; n++) send_item(rand_item());

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d voxel writes and %0d queries, %0d results, %0d saturated",
               writes_sent, queries_sent, results_seen, saturations);
      if (mismatches == 0) begin
         $display("tb_tricubic_volume_resampler OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_tricubic_volume_resampler NOT OK");
      end
      $finish;
   end

endmodule
